// ===== src/sfd_pkg.sv =====
package sfd_pkg;

    // frame format
    localparam logic [7:0] SYNC_BYTE     = 8'h7F;
    localparam int         CTL_FWD_BIT   = 3;
    localparam int         CTL_OVF_BIT   = 0;
    localparam int         MAX_RX        = 8;
    localparam int         IQ_BLOCK_SIZE = 1024;
    localparam int         BLK_W         = (IQ_BLOCK_SIZE > 1) ? $clog2(IQ_BLOCK_SIZE) : 1;

    // configuration register map
    localparam int         ADDR_W     = 3;
    localparam logic       REG_NUM_RX = 1'b0;
    localparam logic [3:0] NUM_RX_RST = 4'd2;

    typedef enum logic [3:0] {
        PH_SYNC0, PH_SYNC1, PH_SYNC2,
        PH_CTL0, PH_CTL1, PH_CTL2, PH_CTL3, PH_CTL4,
        PH_I0, PH_I1, PH_I2, PH_Q0, PH_Q1, PH_Q2,
        PH_MIC0, PH_MIC1
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CTRL = 2'd0,
        KIND_IQ   = 2'd1,
        KIND_MIC  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [2:0]  key_bits;
        logic        adc_overflow;
        logic [7:0]  rx_ver;
        logic [7:0]  tx_ver;
        logic [7:0]  usb_ver;
        logic [15:0] fwd_power;
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         rx_index;
        logic signed [23:0] i_sample;
        logic signed [23:0] q_sample;
        logic signed [15:0] mic_val;
        status_t            status;
        logic               block_done;
    } result_t;

    // receiver count as used by the parser: zero acts as one, clamp at MAX_RX
    function automatic logic [3:0] eff_rx(input logic [3:0] n);
        logic [3:0] r;
        r = n;
        if (r == 4'd0)
            r = 4'd1;
        if (r > 4'(MAX_RX))
            r = 4'(MAX_RX);
        return r;
    endfunction

    // sample groups per frame for a given receiver count
    function automatic logic [5:0] frame_groups(input logic [3:0] n);
        logic [2:0] idx;
        logic [5:0] g;
        idx = 3'(n - 4'd1);
        case (idx)
            3'd0:    g = 6'd63;
            3'd1:    g = 6'd36;
            3'd2:    g = 6'd25;
            3'd3:    g = 6'd19;
            3'd4:    g = 6'd15;
            3'd5:    g = 6'd13;
            3'd6:    g = 6'd11;
            default: g = 6'd10;
        endcase
        return g;
    endfunction

endpackage

// ===== src/sync_frame_iq_deframer_unit.sv =====
// channel   | handshake                | payload
// ----------+--------------------------+----------------------------------------
// input     | in_valid / in_stall      | rx_byte
// result    | out_valid / out_stall    | result_kind .. block_done
// config    | psel/penable/pwrite      | paddr, pwdata, prdata (num_receivers)
//
// one byte per clock while the result register is not held; a byte is registered
// in the input register and its result is loaded into the result register when consumed
// bytes that give no result pass through even while the result register is held
// reset clears the parse phase, counters, status and receiver count (to two)
// a stalled result holds the result register and back-pressures the input register
module sync_frame_iq_deframer_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 result_kind,
    output logic [2:0]                 receiver_index,
    output logic signed [23:0]         i_sample,
    output logic signed [23:0]         q_sample,
    output logic signed [15:0]         mic_value,
    output logic [2:0]                 key_bits,
    output logic                       adc_overflow,
    output logic [7:0]                 rx_board_version,
    output logic [7:0]                 tx_board_version,
    output logic [7:0]                 usb_board_version,
    output logic [15:0]                fwd_power_value,
    output logic                       block_done,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import sfd_pkg::*;

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;
    logic [3:0] num_rx;
    logic       consume;
    logic       emit;
    logic       res_free;
    result_t    res;
    result_t    out_res;

    // input register
    assign in_stall = in_vld_reg && !consume;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (!in_stall)
            in_vld_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
    end

    sfd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .num_rx  (num_rx)
    );

    sfd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld_reg),
        .in_byte  (in_byte_reg),
        .res_free (res_free),
        .num_rx   (num_rx),
        .consume  (consume),
        .emit     (emit),
        .res      (res)
    );

    sfd_result_reg u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume && emit),
        .res       (res),
        .out_stall (out_stall),
        .free      (res_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    // result fields
    assign result_kind       = out_res.kind;
    assign receiver_index    = out_res.rx_index;
    assign i_sample          = out_res.i_sample;
    assign q_sample          = out_res.q_sample;
    assign mic_value         = out_res.mic_val;
    assign key_bits          = out_res.status.key_bits;
    assign adc_overflow      = out_res.status.adc_overflow;
    assign rx_board_version  = out_res.status.rx_ver;
    assign tx_board_version  = out_res.status.tx_ver;
    assign usb_board_version = out_res.status.usb_ver;
    assign fwd_power_value   = out_res.status.fwd_power;
    assign block_done        = out_res.block_done;

    // input register only stalls while holding a byte
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && emit && !res_free)
        else $error("input stalled without cause");

endmodule

// ===== src/sfd_cfg_regs.sv =====
module sfd_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [3:0]                 num_rx
);
    import sfd_pkg::*;

    logic [3:0] num_rx_reg;
    logic [3:0] num_rx_next;
    logic       wr_en;

    // register write on the access phase
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_NUM_RX);

    always_comb
    begin
        num_rx_next = num_rx_reg;
        if (wr_en)
            num_rx_next = pwdata[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_rx_reg <= NUM_RX_RST;
        else
            num_rx_reg <= num_rx_next;
    end

    // read back
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_NUM_RX)
            prdata = {28'd0, num_rx_reg};
    end

    assign pready = 1'b1;
    assign num_rx = num_rx_reg;

endmodule

// ===== src/sfd_parser.sv =====
module sfd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [7:0]       in_byte,
    input  logic             res_free,
    input  logic [3:0]       num_rx,
    output logic             consume,
    output logic             emit,
    output sfd_pkg::result_t res
);
    import sfd_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [7:0]          cb_reg [0:3];
    logic [23:0]         left_reg;
    logic [23:0]         right_reg;
    logic [7:0]          mic_hi_reg;
    logic [2:0]          grp_rx_reg;
    logic [2:0]          grp_rx_next;
    logic [5:0]          grp_frame_reg;
    logic [5:0]          grp_frame_next;
    logic [BLK_W-1:0]    grp_blk_reg;
    logic [BLK_W-1:0]    grp_blk_next;
    status_t             status_reg;
    status_t             status_next;
    logic [3:0]          n_eff;
    logic                is_sync;
    logic                grp_last;
    logic                frame_last;
    logic                blk_last;
    logic [6:0]          frame_inc;
    logic [BLK_W:0]      blk_inc;

    assign n_eff      = eff_rx(num_rx);
    assign is_sync    = (in_byte == SYNC_BYTE);
    assign grp_last   = ({1'b0, grp_rx_reg} + 4'd1) >= n_eff;
    assign frame_inc  = {1'b0, grp_frame_reg} + 7'd1;
    assign frame_last = frame_inc >= {1'b0, frame_groups(n_eff)};
    assign blk_inc    = {1'b0, grp_blk_reg} + {{BLK_W{1'b0}}, 1'b1};
    assign blk_last   = blk_inc >= (BLK_W + 1)'(IQ_BLOCK_SIZE);

    // an item without a result never waits for the result register
    assign consume = in_vld && (res_free || !emit);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SYNC0: phase_next = is_sync ? PH_SYNC1 : PH_SYNC0;
            PH_SYNC1: phase_next = is_sync ? PH_SYNC2 : PH_SYNC0;
            PH_SYNC2: phase_next = is_sync ? PH_CTL0 : PH_SYNC0;
            PH_CTL0:  phase_next = PH_CTL1;
            PH_CTL1:  phase_next = PH_CTL2;
            PH_CTL2:  phase_next = PH_CTL3;
            PH_CTL3:  phase_next = PH_CTL4;
            PH_CTL4:  phase_next = PH_I0;
            PH_I0:    phase_next = PH_I1;
            PH_I1:    phase_next = PH_I2;
            PH_I2:    phase_next = PH_Q0;
            PH_Q0:    phase_next = PH_Q1;
            PH_Q1:    phase_next = PH_Q2;
            PH_Q2:    phase_next = grp_last ? PH_MIC0 : PH_I0;
            PH_MIC0:  phase_next = PH_MIC1;
            PH_MIC1:  phase_next = frame_last ? PH_SYNC0 : PH_I0;
            default:  phase_next = PH_SYNC0;
        endcase
    end

    // status decode on the last control byte
    always_comb
    begin
        status_next = status_reg;
        if (phase_reg == PH_CTL4)
        begin
            status_next.key_bits = cb_reg[0][2:0];
            if (!cb_reg[0][CTL_FWD_BIT])
            begin
                if (cb_reg[1][CTL_OVF_BIT])
                    status_next.adc_overflow = 1'b1;
                status_next.rx_ver  = cb_reg[2];
                status_next.tx_ver  = cb_reg[3];
                status_next.usb_ver = in_byte;
            end
            else
            begin
                status_next.fwd_power = {cb_reg[1], cb_reg[2]};
            end
        end
    end

    // counters
    always_comb
    begin
        grp_rx_next    = grp_rx_reg;
        grp_frame_next = grp_frame_reg;
        grp_blk_next   = grp_blk_reg;
        case (phase_reg)
            PH_CTL0:
            begin
                grp_rx_next    = 3'd0;
                grp_frame_next = 6'd0;
            end
            PH_Q2:
                grp_rx_next = grp_last ? 3'd0 : grp_rx_reg + 3'd1;
            PH_MIC1:
            begin
                grp_frame_next = frame_last ? 6'd0 : frame_inc[5:0];
                grp_blk_next   = blk_last ? '0 : blk_inc[BLK_W-1:0];
            end
            default:
                grp_rx_next = grp_rx_reg;
        endcase
    end

    // result outputs
    always_comb
    begin
        emit           = 1'b0;
        res            = '0;
        res.kind       = KIND_CTRL;
        res.status     = status_next;
        unique case (phase_reg)
            PH_CTL4:
                emit = 1'b1;
            PH_Q2:
            begin
                emit         = 1'b1;
                res.kind     = KIND_IQ;
                res.rx_index = grp_rx_reg;
                res.i_sample = left_reg;
                res.q_sample = {right_reg[23:8], in_byte};
            end
            PH_MIC1:
            begin
                emit           = 1'b1;
                res.kind       = KIND_MIC;
                res.mic_val    = {mic_hi_reg, in_byte};
                res.block_done = blk_last;
            end
            default:
                emit = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC0;
            grp_rx_reg    <= 3'd0;
            grp_frame_reg <= 6'd0;
            grp_blk_reg   <= '0;
            status_reg    <= '0;
        end
        else if (consume)
        begin
            phase_reg     <= phase_next;
            grp_rx_reg    <= grp_rx_next;
            grp_frame_reg <= grp_frame_next;
            grp_blk_reg   <= grp_blk_next;
            status_reg    <= status_next;
        end
    end

    // byte assembly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_reg[0]  <= 8'd0;
            cb_reg[1]  <= 8'd0;
            cb_reg[2]  <= 8'd0;
            cb_reg[3]  <= 8'd0;
            left_reg   <= 24'd0;
            right_reg  <= 24'd0;
            mic_hi_reg <= 8'd0;
        end
        else if (consume)
        begin
            case (phase_reg)
                PH_CTL0: cb_reg[0] <= in_byte;
                PH_CTL1: cb_reg[1] <= in_byte;
                PH_CTL2: cb_reg[2] <= in_byte;
                PH_CTL3: cb_reg[3] <= in_byte;
                PH_I0:   left_reg  <= {in_byte, 16'd0};
                PH_I1:   left_reg  <= {left_reg[23:16], in_byte, 8'd0};
                PH_I2:   left_reg  <= {left_reg[23:8], in_byte};
                PH_Q0:   right_reg <= {in_byte, 16'd0};
                PH_Q1:   right_reg <= {right_reg[23:16], in_byte, 8'd0};
                PH_Q2:   right_reg <= {right_reg[23:8], in_byte};
                PH_MIC0: mic_hi_reg <= in_byte;
                default: mic_hi_reg <= mic_hi_reg;
            endcase
        end
    end

    // block counter always below the block size
    a_blk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (BLK_W + 1)'(grp_blk_reg) < (BLK_W + 1)'(IQ_BLOCK_SIZE))
        else $error("block counter out of range");

    // a frame starts with a cleared group count
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        consume && phase_reg == PH_CTL0 |=> grp_frame_reg == 6'd0 && grp_rx_reg == 3'd0)
        else $error("group counters not cleared at frame start");

endmodule

// ===== src/sfd_result_reg.sv =====
module sfd_result_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sfd_pkg::result_t    res,
    input  logic                out_stall,
    output logic                free,
    output logic                out_valid,
    output sfd_pkg::result_t    out_res
);
    import sfd_pkg::*;

    logic    out_vld_reg;
    logic    out_vld_next;
    result_t res_reg;

    // slot can take a new transaction when empty or being drained
    assign free = !out_vld_reg || !out_stall;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load)
            out_vld_next = 1'b1;
        else if (!out_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = out_vld_reg;
    assign out_res   = res_reg;

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall |-> !load)
        else $error("held result overwritten");

    // block flag only on a mic result
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.block_done |-> res_reg.kind == KIND_MIC)
        else $error("block flag on a non-mic result");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HALF_PERIOD = 2;
    localparam logic [ADDR_W-1:0] NUM_RX_ADDR = ADDR_W'(4 * int'(REG_NUM_RX));

    // dut ports, all inputs known from time zero
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          rx_byte = 8'h00;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          result_kind;
    logic [2:0]          receiver_index;
    logic signed [23:0]  i_sample;
    logic signed [23:0]  q_sample;
    logic signed [15:0]  mic_value;
    logic [2:0]          key_bits;
    logic                adc_overflow;
    logic [7:0]          rx_board_version;
    logic [7:0]          tx_board_version;
    logic [7:0]          usb_board_version;
    logic [15:0]         fwd_power_value;
    logic                block_done;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    sync_frame_iq_deframer_unit u_top (.*);

    always #(HALF_PERIOD) clk = ~clk;

    // byte stream waiting to be sent, decoded results still to arrive
    logic [7:0] byte_q [$];
    result_t    pending_results [$];

    // shadow of the deframer state
    phase_t     prs_phase = PH_SYNC0;
    logic [7:0] ctl_b [4] = '{default: 8'h00};
    logic [23:0] i_acc = '0;
    logic [23:0] q_acc = '0;
    logic [7:0] mic_hi = 8'h00;
    int         cur_rx = 0;
    int         grp_in_frame = 0;
    int         grp_in_blk = 0;
    status_t    st = '0;
    logic [3:0] rx_cfg = 4'd2;
    int         grp_limit [8] = '{63, 36, 25, 19, 15, 13, 11, 10};

    // idle behaviour of both sides
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    // bookkeeping
    int cycles = 0;
    int n_fail = 0;
    int n_bytes = 0;
    int n_results = 0;
    int n_blocks = 0;
    logic in_taken = 1'b0;

    logic [3:0] cfg_plan [5] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3};

    // receiver count in force: zero acts as one, clamp at the maximum
    function automatic int rx_in_force();
        if (rx_cfg == 4'd0)
            return 1;
        if (int'(rx_cfg) > MAX_RX)
            return MAX_RX;
        return int'(rx_cfg);
    endfunction

    // advance the shadow parser by one byte and queue any decoded result
    function automatic void parse_byte(input logic [7:0] b);
        result_t r;
        int      nrx;
        bit      emit;
        nrx = rx_in_force();
        r = '0;
        emit = 1'b0;
        case (prs_phase)
            PH_SYNC0: if (b == SYNC_BYTE) prs_phase = PH_SYNC1;
            PH_SYNC1: prs_phase = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC0;
            PH_SYNC2: prs_phase = (b == SYNC_BYTE) ? PH_CTL0 : PH_SYNC0;
            PH_CTL0:
            begin
                cur_rx = 0;
                grp_in_frame = 0;
                ctl_b[0] = b;
                prs_phase = PH_CTL1;
            end
            PH_CTL1:
            begin
                ctl_b[1] = b;
                prs_phase = PH_CTL2;
            end
            PH_CTL2:
            begin
                ctl_b[2] = b;
                prs_phase = PH_CTL3;
            end
            PH_CTL3:
            begin
                ctl_b[3] = b;
                prs_phase = PH_CTL4;
            end
            PH_CTL4:
            begin
                st.key_bits = ctl_b[0][2:0];
                if (!ctl_b[0][CTL_FWD_BIT])
                begin
                    if (ctl_b[1][CTL_OVF_BIT])
                        st.adc_overflow = 1'b1;
                    st.rx_ver = ctl_b[2];
                    st.tx_ver = ctl_b[3];
                    st.usb_ver = b;
                end
                else
                begin
                    st.fwd_power = {ctl_b[1], ctl_b[2]};
                end
                r.kind = KIND_CTRL;
                emit = 1'b1;
                prs_phase = PH_I0;
            end
            PH_I0:
            begin
                i_acc = {b, 16'h0000};
                prs_phase = PH_I1;
            end
            PH_I1:
            begin
                i_acc[15:8] = b;
                prs_phase = PH_I2;
            end
            PH_I2:
            begin
                i_acc[7:0] = b;
                prs_phase = PH_Q0;
            end
            PH_Q0:
            begin
                q_acc = {b, 16'h0000};
                prs_phase = PH_Q1;
            end
            PH_Q1:
            begin
                q_acc[15:8] = b;
                prs_phase = PH_Q2;
            end
            PH_Q2:
            begin
                q_acc[7:0] = b;
                r.kind = KIND_IQ;
                r.rx_index = 3'(cur_rx);
                r.i_sample = i_acc;
                r.q_sample = q_acc;
                emit = 1'b1;
                // group ends once the count in force is reached or passed
                if (cur_rx + 1 >= nrx)
                begin
                    cur_rx = 0;
                    prs_phase = PH_MIC0;
                end
                else
                begin
                    cur_rx = (cur_rx + 1) % 8;
                    prs_phase = PH_I0;
                end
            end
            PH_MIC0:
            begin
                mic_hi = b;
                prs_phase = PH_MIC1;
            end
            default:
            begin
                // second mic byte closes the group
                r.kind = KIND_MIC;
                r.mic_val = {mic_hi, b};
                emit = 1'b1;
                grp_in_blk++;
                if (grp_in_blk >= IQ_BLOCK_SIZE)
                begin
                    grp_in_blk = 0;
                    r.block_done = 1'b1;
                end
                grp_in_frame++;
                if (grp_in_frame >= grp_limit[nrx - 1])
                begin
                    grp_in_frame = 0;
                    prs_phase = PH_SYNC0;
                end
                else
                begin
                    prs_phase = PH_I0;
                end
            end
        endcase
        if (emit)
        begin
            r.status = st;
            pending_results.push_back(r);
        end
    endfunction

    function automatic void cmp(input string fname, input logic [23:0] e,
                                input logic [23:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, actual %0h", fname, e, a);
            n_fail++;
        end
    endfunction

    // compare one result transaction with the oldest decoded expectation
    function automatic void check_result();
        result_t e;
        if (pending_results.size() == 0)
        begin
            $error("result_kind: expected nothing, actual %0h", result_kind);
            n_fail++;
        end
        else
        begin
            e = pending_results.pop_front();
            n_results++;
            if (block_done === 1'b1)
                n_blocks++;
            cmp("result_kind", e.kind, result_kind);
            cmp("receiver_index", e.rx_index, receiver_index);
            cmp("i_sample", e.i_sample, i_sample);
            cmp("q_sample", e.q_sample, q_sample);
            cmp("mic_value", e.mic_val, mic_value);
            cmp("key_bits", e.status.key_bits, key_bits);
            cmp("adc_overflow", e.status.adc_overflow, adc_overflow);
            cmp("rx_board_version", e.status.rx_ver, rx_board_version);
            cmp("tx_board_version", e.status.tx_ver, tx_board_version);
            cmp("usb_board_version", e.status.usb_ver, usb_board_version);
            cmp("fwd_power_value", e.status.fwd_power, fwd_power_value);
            cmp("block_done", e.block_done, block_done);
        end
    endfunction

    // sample of 3 or 2 bytes, big-endian, often one of the extremes
    function automatic void push_sample(input int nb);
        logic [23:0] v;
        case ($urandom_range(9))
            0: v = 24'h000000;
            1: v = 24'hFFFFFF;
            2: v = 24'h800000;
            3: v = 24'h7FFFFF;
            default: v = 24'($urandom);
        endcase
        for (int k = 0; k < nb; k++)
            byte_q.push_back(v[23 - 8 * k -: 8]);
    endfunction

    function automatic logic [7:0] non_sync_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == SYNC_BYTE)
            v = 8'h00;
        return v;
    endfunction

    // frame header, sometimes led by noise and a broken sync run
    function automatic void push_header(input bit fwd);
        logic [7:0] c0;
        logic [7:0] c1;
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(1, 4)) byte_q.push_back(non_sync_byte());
            // broken sync run
            repeat ($urandom_range(1, 2)) byte_q.push_back(SYNC_BYTE);
            byte_q.push_back(non_sync_byte());
        end
        repeat (3) byte_q.push_back(SYNC_BYTE);
        c0 = 8'($urandom);
        c0[CTL_FWD_BIT] = fwd;
        c1 = 8'($urandom);
        c1[CTL_OVF_BIT] = ($urandom_range(15) == 0);
        byte_q.push_back(c0);
        byte_q.push_back(c1);
        repeat (3) byte_q.push_back(8'($urandom));
    endfunction

    // sample groups for the given receiver count
    function automatic void push_groups(input int nrx, input int ngrp);
        repeat (ngrp)
        begin
            repeat (nrx)
            begin
                push_sample(3);
                push_sample(3);
            end
            push_sample(2);
        end
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (byte_q.size() != 0 || in_valid || pending_results.size() != 0);
        // bytes without a result may still sit in the input register
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rx_count(input logic [3:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= NUM_RX_ADDR;
        pwdata <= {28'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rx_cfg = val;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // byte driver: next transaction once the previous one has been taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                rx_byte <= byte_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < snk_stall_pct);

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        cycles++;
        in_taken <= in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
            check_result();
        if (rst_n && in_valid && !in_stall)
        begin
            n_bytes++;
            parse_byte(rx_byte);
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        logic [3:0] cfg_val;
        int         ngrp;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hunt restarts after one and two sync bytes, a status frame
        // with all key bits and overflow, then largest and most negative samples
        byte_q = '{8'h7F, 8'h00, 8'h7F, 8'h7F, 8'h01, 8'h7F, 8'h7F, 8'h7F,
                   8'h07, 8'h01, 8'hFF, 8'h00, 8'hA5,
                   8'h7F, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00};
        wait_idle();

        // settings change between phases, inside a frame or while hunting
        for (int p = 0; p < 9; p++)
        begin
            cfg_val = (p < 5) ? cfg_plan[p] : 4'($urandom_range(0, 15));
            write_rx_count(cfg_val);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
                default: begin src_idle_pct = 16; snk_stall_pct = 16; end
            endcase
            @(posedge clk);
            // a hunting parser gets a fresh frame header first
            if (prs_phase inside {PH_SYNC0, PH_SYNC1, PH_SYNC2})
                push_header($urandom_range(1) == 1);
            // single-receiver groups first build up the frame count
            ngrp = (p == 0) ? 9 : 1;
            push_groups(rx_in_force(), ngrp);
            if (p == 1)
            begin
                // the wide group reaches the smaller frame limit, a new frame follows
                push_header(1'b1);
                push_groups(rx_in_force(), 1);
            end
            else if (p > 1 && $urandom_range(2) == 0)
            begin
                // stop short so the next setting can land inside a group
                repeat ($urandom_range(1, 12)) void'(byte_q.pop_back());
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("sent %0d bytes across in and out of range receiver counts, checked %0d results",
                 n_bytes, n_results);
        $display("iq blocks completed: %0d, mismatches: %0d", n_blocks, n_fail);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sfd_pkg.sv
src/sfd_cfg_regs.sv
src/sfd_parser.sv
src/sfd_result_reg.sv
src/sync_frame_iq_deframer_unit.sv
tb/tb.sv
